@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the timer bank RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hdl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic task timer bank package
// Sizes, command and result codes, and shared types of the timer bank.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int unsigned SLOT_COUNT = 8;
  localparam int unsigned TICK_US    = 1000;

  localparam int unsigned SLOT_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W    = $clog2(SLOT_COUNT + 1);
  localparam int unsigned TICK_W   = $clog2(TICK_US + 1);
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned ENTRY_W  = 2 * TICKS_W;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned SLOT_FW  = 3;
  localparam int unsigned PERIOD_W = 32;

  // Reciprocal of the tick length, scaled by 2^PERIOD_W and rounded down.
  localparam logic [PERIOD_W:0] MAGIC_WIDE =
    (PERIOD_W + 1)'((64'd1 << PERIOD_W) / TICK_US);
  localparam logic [PERIOD_W-1:0] DIV_MAGIC =
    MAGIC_WIDE[PERIOD_W] ? {PERIOD_W{1'b1}} : MAGIC_WIDE[PERIOD_W-1:0];
  localparam logic [TICK_W-1:0] TICK_DIVISOR = TICK_W'(TICK_US);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_DISPATCH = 2'd2
  } ptt_cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT = 3'd0,
    KIND_REJECT = 3'd1,
    KIND_DUE    = 3'd2,
    KIND_IDLE   = 3'd3,
    KIND_NONE   = 3'd4
  } ptt_kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_WALK,
    S_FIN
  } ptt_state_e;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MUL,
    DV_QUOT,
    DV_BACK,
    DV_CORR
  } ptt_div_state_e;

  typedef struct packed {
    logic                start;
    logic [PERIOD_W-1:0] interval;
  } ptt_div_req_t;

  typedef struct packed {
    logic               done;
    logic [TICKS_W-1:0] ticks;
  } ptt_div_rsp_t;

  function automatic logic [SLOT_FW-1:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+SLOT_FW-1:0] wide;
    wide = {{SLOT_FW{1'b0}}, idx};
    return wide[SLOT_FW-1:0];
  endfunction

endpackage

@@ hdl/periodic_task_timer_bank.sv @@
// ----------------------------------------------------------------------------
// Periodic task timer bank
// A bank of periodic countdown timers, one per task slot, kept in one RAM.
// ----------------------------------------------------------------------------
// The input channel takes one command word (add, tick or dispatch) at a time
// on in_valid_i/in_stall_o; in_stall_o is high while a command is in work.
// Results leave on out_valid_o/out_stall_i through an output register, so the
// next command is taken while a result still waits for the receiver.
// An add converts the period to ticks in the divider unit and returns one
// word (accepted with its slot, or rejected).
// A tick or a dispatch walks the used slots through the RAM at one slot per
// cycle while not held by a stalled receiver, a read-modify-write with a
// registered read.
// A dispatch returns one word per due slot in slot order, or one idle or
// nothing-due word; the last word of each command carries last_o.
// A stalled receiver holds the output register, and the walk waits in place.
// idle_enabled_i is written into a register when cfg_we_i is high.
// Reset empties the bank and clears the idle flag; the RAM needs no clearing
// because only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module periodic_task_timer_bank import ptt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                idle_enabled_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic                task_valid_i,
  input  logic [PERIOD_W-1:0] interval_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [KIND_W-1:0]   kind_o,
  output logic [SLOT_FW-1:0]  slot_o,
  output logic                last_o
);

  ptt_state_e state_q, state_d;

  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CNT_W-1:0]   nxt_q, nxt_d;
  logic [SLOT_W-1:0]  p_idx_q, p_idx_d;
  logic               hv_q, hv_d;
  logic [SLOT_W-1:0]  h_slot_q, h_slot_d;
  ptt_kind_e          res_kind_q, res_kind_d;
  logic [SLOT_FW-1:0] res_slot_q, res_slot_d;
  logic               idle_en_q;

  logic               out_v_q;
  ptt_kind_e          out_kind_q;
  logic [SLOT_FW-1:0] out_slot_q;
  logic               out_last_q;

  logic               push;
  ptt_kind_e          push_kind;
  logic [SLOT_FW-1:0] push_slot;
  logic               push_last;
  logic               out_free;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [SLOT_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TICKS_W-1:0] rd_period;
  logic [TICKS_W-1:0] rd_delay;
  logic               due;
  logic               blocked;

  ptt_div_req_t       div_req;
  ptt_div_rsp_t       div_rsp;

  ptt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ptt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign rd_period  = ram_rdata[ENTRY_W-1:TICKS_W];
  assign rd_delay   = ram_rdata[TICKS_W-1:0];
  assign out_free   = !out_v_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  assign out_valid_o = out_v_q;
  assign kind_o      = out_kind_q;
  assign slot_o      = out_slot_q;
  assign last_o      = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmd_q     <= '0;
      used_q    <= '0;
      nxt_q     <= '0;
      p_idx_q   <= '0;
      hv_q      <= 1'b0;
      idle_en_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      used_q  <= used_d;
      nxt_q   <= nxt_d;
      p_idx_q <= p_idx_d;
      hv_q    <= hv_d;
      if (cfg_we_i) begin
        idle_en_q <= idle_enabled_i;
      end
      if (push) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_slot_q   <= h_slot_d;
    res_kind_q <= res_kind_d;
    res_slot_q <= res_slot_d;
    if (push) begin
      out_kind_q <= push_kind;
      out_slot_q <= push_slot;
      out_last_q <= push_last;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_d            = cmd_q;
    used_d           = used_q;
    nxt_d            = nxt_q;
    p_idx_d          = p_idx_q;
    hv_d             = hv_q;
    h_slot_d         = h_slot_q;
    res_kind_d       = res_kind_q;
    res_slot_d       = res_slot_q;
    ram_we           = 1'b0;
    ram_waddr        = p_idx_q;
    ram_wdata        = {rd_period, rd_delay};
    ram_re           = 1'b0;
    ram_raddr        = nxt_q[SLOT_W-1:0];
    push             = 1'b0;
    push_kind        = KIND_DUE;
    push_slot        = slot_field(h_slot_q);
    push_last        = 1'b0;
    div_req.start    = 1'b0;
    div_req.interval = interval_i;
    due              = (cmd_q == CMD_DISPATCH) && (rd_delay == '0);
    blocked          = due && hv_q && !out_free;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_i;
          case (cmd_i)
            CMD_ADD: begin
              if ((used_q >= CNT_W'(SLOT_COUNT)) || !task_valid_i) begin
                res_kind_d = KIND_REJECT;
                res_slot_d = '0;
                state_d    = S_FIN;
              end else begin
                div_req.start = 1'b1;
                state_d       = S_DIV;
              end
            end
            CMD_TICK, CMD_DISPATCH: begin
              if (used_q == '0) begin
                if (cmd_i == CMD_DISPATCH) begin
                  res_kind_d = idle_en_q ? KIND_IDLE : KIND_NONE;
                  res_slot_d = '0;
                  state_d    = S_FIN;
                end
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                p_idx_d   = '0;
                nxt_d     = CNT_W'(1);
                hv_d      = 1'b0;
                state_d   = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          ram_we     = 1'b1;
          ram_waddr  = used_q[SLOT_W-1:0];
          ram_wdata  = {div_rsp.ticks, div_rsp.ticks};
          res_kind_d = KIND_ACCEPT;
          res_slot_d = slot_field(used_q[SLOT_W-1:0]);
          used_d     = used_q + CNT_W'(1);
          state_d    = S_FIN;
        end
      end
      S_WALK: begin
        if (!blocked) begin
          if (due) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_period, rd_period};
            if (hv_q) begin
              push      = 1'b1;
              push_kind = KIND_DUE;
              push_slot = slot_field(h_slot_q);
              push_last = 1'b0;
            end
            hv_d     = 1'b1;
            h_slot_d = p_idx_q;
          end else if ((cmd_q == CMD_TICK) && (rd_delay != '0)) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_period, rd_delay - TICKS_W'(1)};
          end
          if (nxt_q < used_q) begin
            ram_re  = 1'b1;
            p_idx_d = nxt_q[SLOT_W-1:0];
            nxt_d   = nxt_q + CNT_W'(1);
          end else begin
            hv_d = 1'b0;
            if (cmd_q == CMD_DISPATCH) begin
              state_d = S_FIN;
              if (due) begin
                res_kind_d = KIND_DUE;
                res_slot_d = slot_field(p_idx_q);
              end else if (hv_q) begin
                res_kind_d = KIND_DUE;
                res_slot_d = slot_field(h_slot_q);
              end else begin
                res_kind_d = idle_en_q ? KIND_IDLE : KIND_NONE;
                res_slot_d = '0;
              end
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          push      = 1'b1;
          push_kind = res_kind_q;
          push_slot = res_slot_q;
          push_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_used_bound, clk_i, rst_ni, used_q <= CNT_W'(SLOT_COUNT), "fill count overflow")
  `ASSERT_ALWAYS(a_div_done_in_div, clk_i, rst_ni, div_rsp.done |-> (state_q == S_DIV), "stray divider result")
  `ASSERT_ALWAYS(a_walk_write_used, clk_i, rst_ni, (ram_we && (state_q == S_WALK)) |-> (p_idx_q < used_q), "write to unused slot")
  `ASSERT_NEVER(a_push_into_full, clk_i, rst_ni, push && out_v_q && out_stall_i, "result word overwritten")
  `ASSERT_ALWAYS(a_held_only_in_walk, clk_i, rst_ni, hv_q |-> (state_q == S_WALK), "held due slot outside walk")

endmodule

@@ hdl/ptt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ptt_div.sv @@
// ----------------------------------------------------------------------------
// Period to tick converter
// Divides a period by the tick length through a reciprocal multiply, a
// back multiply and compare-subtract correction, then clamps to 1..65535.
// ----------------------------------------------------------------------------
module ptt_div import ptt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ptt_div_req_t req_i,
  output ptt_div_rsp_t rsp_o
);

  ptt_div_state_e state_q, state_d;

  logic [PERIOD_W-1:0]        x_q, x_d;
  logic [2*PERIOD_W-1:0]      prod_q, prod_d;
  logic [PERIOD_W-1:0]        q_q, q_d;
  logic [PERIOD_W-1:0]        r_q, r_d;
  logic [PERIOD_W+TICK_W-1:0] back;
  logic [PERIOD_W-1:0]        divisor;
  logic                       dv_done;
  logic [TICKS_W-1:0]         dv_ticks;

  assign divisor = PERIOD_W'(TICK_DIVISOR);
  assign rsp_o   = '{done: dv_done, ticks: dv_ticks};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    prod_q <= prod_d;
    q_q    <= q_d;
    r_q    <= r_d;
  end

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    prod_d  = prod_q;
    q_d     = q_q;
    r_d     = r_q;
    back    = {{TICK_W{1'b0}}, q_q} * {{PERIOD_W{1'b0}}, TICK_DIVISOR};
    dv_done = 1'b0;
    case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          x_d     = req_i.interval;
          state_d = DV_MUL;
        end
      end
      DV_MUL: begin
        prod_d  = {{PERIOD_W{1'b0}}, x_q} * {{PERIOD_W{1'b0}}, DIV_MAGIC};
        state_d = DV_QUOT;
      end
      DV_QUOT: begin
        q_d     = prod_q[2*PERIOD_W-1:PERIOD_W];
        state_d = DV_BACK;
      end
      DV_BACK: begin
        r_d     = x_q - back[PERIOD_W-1:0];
        state_d = DV_CORR;
      end
      DV_CORR: begin
        if (r_q >= divisor) begin
          r_d = r_q - divisor;
          q_d = q_q + PERIOD_W'(1);
        end else begin
          dv_done = 1'b1;
          state_d = DV_IDLE;
        end
      end
      default: begin
        state_d = DV_IDLE;
      end
    endcase
  end

  always_comb begin
    if (|q_q[PERIOD_W-1:TICKS_W]) begin
      dv_ticks = {TICKS_W{1'b1}};
    end else if (q_q[TICKS_W-1:0] == '0) begin
      dv_ticks = TICKS_W'(1);
    end else begin
      dv_ticks = q_q[TICKS_W-1:0];
    end
  end

endmodule
